// ===== rtl/core/brlc_pkg.sv =====
// ----------------------------------------------------------------------------
// brlc_pkg
// shared types and codes of the byte capacity lru cache directory
// ----------------------------------------------------------------------------
package brlc_pkg;

	localparam int KEY_W  = 48;
	localparam int SIZE_W = 40;
	localparam int CNT_W  = 32;
	localparam int SLOT_W = 4;

	// result kind codes
	typedef enum logic [2:0] {
		KIND_HIT     = 3'd0,
		KIND_INSERT  = 3'd1,
		KIND_TOOBIG  = 3'd2,
		KIND_BYPASS  = 3'd3,
		KIND_EVICT   = 3'd4,
		KIND_CLEARED = 3'd5
	} kind_t;

	// request commands
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// operation broadcast to the cell row
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_EVICT = 2'd1,
		OP_MOVE  = 2'd2,
		OP_WRITE = 2'd3
	} cell_op_t;

	// word carried along the cell row: data of the picked cell
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [7:0]        rank;
	} chain_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  entry_key;
		logic [SIZE_W-1:0] used_bytes;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
		logic [CNT_W-1:0]  evict_count;
		logic              last;
	} result_t;

endpackage

// ===== rtl/core/brlc_if.sv =====
// ----------------------------------------------------------------------------
// brlc interfaces
// request and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface brlc_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [47:0] key;
	logic [39:0] size_bytes;
	modport source (output valid, command, key, size_bytes, input ready);
	modport sink   (input valid, command, key, size_bytes, output ready);
endinterface

interface brlc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  slot;
	logic [47:0] entry_key;
	logic [39:0] used_bytes;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] evict_count;
	logic        last;
	modport source (output valid, kind, slot, entry_key, used_bytes, hit_count, miss_count,
		evict_count, last, input ready);
	modport sink   (input valid, kind, slot, entry_key, used_bytes, hit_count, miss_count,
		evict_count, last, output ready);
endinterface

// ===== rtl/core/byte_capacity_lru_cache.sv =====
// ----------------------------------------------------------------------------
// byte_capacity_lru_cache
// size aware lru directory built from a row of entry cells and a sequencer
// ----------------------------------------------------------------------------
// channel  dir  words
// req      in   command, key, size_bytes
// res      out  kind, slot, entry_key, used_bytes, counters, last
// cfg      in   capacity_bytes write (cfg_we, cfg_wdata)
//
// a lookup registers the request, does the tag match, then registers the result.
// an insertion scans recency ranks from least recent down, one rank a cycle
// while res is not stalled; a clear scans every rank and evicts each valid entry.
// each result waits in the output register while res is stalled.
// reset empties the directory at once; no clearing pass.
module byte_capacity_lru_cache #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata,
	brlc_req_if.sink    req,
	brlc_res_if.source  res
);
	import brlc_pkg::*;

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_LOOK, S_SCAN, S_INS, S_CLR_END
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] cap_q;
	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [RW-1:0]     scan_q;
	logic [SIZE_W:0]   used_q;
	logic [CNT_W-1:0]  hits_q, misses_q, evicts_q;
	logic              out_vld_q;
	result_t           out_q;

	cell_op_t           op;
	logic [ENTRIES-1:0] pick, valid_v, hit_v, rank_eq_v;
	chain_t             chain [ENTRIES+1];
	logic [RW-1:0]      ref_rank;

	// cell row
	assign chain[0] = '0;
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		brlc_cell #(.RW(RW), .IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .op(op), .pick(pick[i]),
			.ref_rank(ref_rank), .scan_rank(scan_q),
			.req_key(key_q), .req_size(size_q),
			.chain_in(chain[i]), .chain_out(chain[i+1]),
			.valid(valid_v[i]), .hit(hit_v[i]), .rank_eq(rank_eq_v[i])
		);
	end
	assign ref_rank = chain[ENTRIES].rank[RW-1:0];

	// hit slot and lowest free slot
	logic [RW-1:0] hit_idx, free_idx;
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_v[i]) hit_idx = RW'(i);
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!valid_v[i]) free_idx = RW'(i);
	end

	logic            any_hit, any_free, pv, over, bypass, can_step;
	logic [RW-1:0]   pick_idx;
	logic [SIZE_W:0] used_ev;
	assign any_hit  = |hit_v;
	assign any_free = ~&valid_v;
	assign pv       = |(rank_eq_v & valid_v);
	assign over     = ({1'b0, used_q} + {2'b0, size_q}) > {2'b0, cap_q};
	assign bypass   = cap_q == '0 || size_q == '0 || key_q == '0;
	assign can_step = !out_vld_q || res.ready;
	assign used_ev  = used_q - {1'b0, chain[ENTRIES].size};

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (rank_eq_v[i]) pick_idx = RW'(i);
	end

	// cell command for this cycle
	always_comb begin
		op   = OP_NONE;
		pick = '0;
		case (state_q)
			S_LOOK: begin
				if (can_step && cmd_q == CMD_LOOKUP && !bypass && any_hit) begin
					op   = OP_MOVE;
					pick = hit_v;
				end
			end
			S_SCAN: begin
				pick = rank_eq_v;
				if (can_step && pv && (cmd_q == CMD_CLEAR || over || !any_free))
					op = OP_EVICT;
			end
			S_INS: begin
				pick = ENTRIES'(1) << free_idx;
				if (can_step) op = OP_WRITE;
			end
			default: ;
		endcase
	end

	assign req.ready = state_q == S_IDLE;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= '0;
			scan_q    <= '0;
			used_q    <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
			out_vld_q <= 1'b0;
			cmd_q     <= CMD_LOOKUP;
			key_q     <= '0;
			size_q    <= '0;
			out_q     <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (out_vld_q && res.ready) out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.command;
						key_q   <= req.key;
						size_q  <= req.size_bytes;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (can_step) begin
						scan_q <= RW'(ENTRIES - 1);
						if (cmd_q == CMD_CLEAR) begin
							state_q <= S_SCAN;
						end else if (bypass) begin
							out_vld_q <= 1'b1;
							out_q <= '{KIND_BYPASS, '0, key_q, used_q[SIZE_W-1:0],
								hits_q, misses_q, evicts_q, 1'b1};
							state_q <= S_IDLE;
						end else if (any_hit) begin
							hits_q    <= sat_inc(hits_q);
							out_vld_q <= 1'b1;
							out_q <= '{KIND_HIT, SLOT_W'(hit_idx), key_q,
								used_q[SIZE_W-1:0], sat_inc(hits_q), misses_q,
								evicts_q, 1'b1};
							state_q <= S_IDLE;
						end else begin
							misses_q <= sat_inc(misses_q);
							if (size_q > cap_q) begin
								out_vld_q <= 1'b1;
								out_q <= '{KIND_TOOBIG, '0, key_q, used_q[SIZE_W-1:0],
									hits_q, sat_inc(misses_q), evicts_q, 1'b1};
								state_q <= S_IDLE;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (can_step) begin
						if (op == OP_EVICT) begin
							used_q    <= used_ev;
							evicts_q  <= sat_inc(evicts_q);
							out_vld_q <= 1'b1;
							out_q <= '{KIND_EVICT, SLOT_W'(pick_idx), chain[ENTRIES].key,
								used_ev[SIZE_W-1:0], hits_q, misses_q,
								sat_inc(evicts_q), 1'b0};
						end
						if (cmd_q == CMD_CLEAR) begin
							if (scan_q == '0) state_q <= S_CLR_END;
							else scan_q <= scan_q - RW'(1);
						end else if (!over || scan_q == '0) begin
							state_q <= S_INS;
						end else begin
							scan_q <= scan_q - RW'(1);
						end
					end
				end
				S_INS: begin
					if (can_step) begin
						used_q    <= used_q + {1'b0, size_q};
						out_vld_q <= 1'b1;
						out_q <= '{KIND_INSERT, SLOT_W'(free_idx), key_q,
							SIZE_W'(used_q + {1'b0, size_q}), hits_q, misses_q,
							evicts_q, 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_CLR_END: begin
					if (can_step) begin
						used_q    <= '0;
						out_vld_q <= 1'b1;
						out_q <= '{KIND_CLEARED, '0, key_q, '0, hits_q, misses_q,
							evicts_q, 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid       = out_vld_q;
	assign res.kind        = out_q.kind;
	assign res.slot        = out_q.slot;
	assign res.entry_key   = out_q.entry_key;
	assign res.used_bytes  = out_q.used_bytes;
	assign res.hit_count   = out_q.hit_count;
	assign res.miss_count  = out_q.miss_count;
	assign res.evict_count = out_q.evict_count;
	assign res.last        = out_q.last;

	// ranks stay a permutation
	a_rank_perm: assert property (@(posedge clk) disable iff (!arst_n) $onehot(rank_eq_v))
		else $error("rank scan selects no or several cells");
	// at most one cell picked
	a_pick: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(pick))
		else $error("several cells picked");
	// insertion always finds a free slot
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> any_free)
		else $error("insert without free slot");
	// the sequencer never overwrites a waiting result
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !res.ready) |=> $stable(out_q))
		else $error("waiting result overwritten");

endmodule

// ===== rtl/core/brlc_cell.sv =====
// ----------------------------------------------------------------------------
// brlc_cell
// one directory entry: valid, key, size and recency rank, with match logic
// ----------------------------------------------------------------------------
module brlc_cell #(
	parameter int RW  = 4,
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  brlc_pkg::cell_op_t         op,
	input  logic                       pick,
	input  logic [RW-1:0]              ref_rank,
	input  logic [RW-1:0]              scan_rank,
	input  logic [brlc_pkg::KEY_W-1:0]  req_key,
	input  logic [brlc_pkg::SIZE_W-1:0] req_size,
	input  brlc_pkg::chain_t           chain_in,
	output brlc_pkg::chain_t           chain_out,
	output logic                       valid,
	output logic                       hit,
	output logic                       rank_eq
);
	import brlc_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [RW-1:0]     rank_q;

	assign valid   = valid_q;
	assign hit     = valid_q && key_q == req_key && size_q == req_size;
	assign rank_eq = rank_q == scan_rank;

	// pass the picked cell's data down the row
	always_comb begin
		chain_out = chain_in;
		if (pick) begin
			chain_out.key  = chain_in.key | key_q;
			chain_out.size = chain_in.size | size_q;
			chain_out.rank = chain_in.rank | 8'(rank_q);
		end
	end

	// control state: valid and rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= RW'(IDX);
		end else begin
			case (op)
				OP_EVICT: begin
					if (pick) valid_q <= 1'b0;
				end
				OP_MOVE, OP_WRITE: begin
					if (pick) begin
						rank_q <= '0;
						if (op == OP_WRITE) valid_q <= 1'b1;
					end else if (rank_q < ref_rank) begin
						rank_q <= rank_q + RW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (op == OP_WRITE && pick) begin
			key_q  <= req_key;
			size_q <= req_size;
		end
	end

endmodule

// ===== verif/brlc_lru_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brlc_lru_checker
// watches the request and result channels of the lru cache directory, keeps
// its own copy of the directory and compares every result word in order
// ----------------------------------------------------------------------------
module brlc_lru_checker #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [brlc_pkg::SIZE_W-1:0] cfg_wdata,
	brlc_req_if                         req,
	brlc_res_if                         res,
	output int                          fail_count,
	output int                          pending_results
);
	import brlc_pkg::*;

	localparam logic [CNT_W-1:0] CNT_TOP = '1;

	// directory copy
	logic [SIZE_W-1:0] capacity;
	logic              held [ENTRIES];
	logic [KEY_W-1:0]  held_key [ENTRIES];
	logic [SIZE_W-1:0] held_size [ENTRIES];
	int                rank [ENTRIES];
	logic [SIZE_W:0]   bytes_held;
	logic [CNT_W-1:0]  hits, misses, evictions;

	result_t expected_words [$];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_TOP) ? c : c + CNT_W'(1);
	endfunction

	function automatic void push_word(input kind_t k, input int s, input logic [KEY_W-1:0] kk);
		result_t w;
		w.kind        = k;
		w.slot        = s[SLOT_W-1:0];
		w.entry_key   = kk;
		w.used_bytes  = bytes_held[SIZE_W-1:0];
		w.hit_count   = hits;
		w.miss_count  = misses;
		w.evict_count = evictions;
		w.last        = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void to_front(input int s);
		int r;
		r = rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (rank[i] < r) rank[i]++;
		rank[s] = 0;
	endfunction

	function automatic int oldest_slot();
		int b;
		b = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (held[i] && (b < 0 || rank[i] > rank[b])) b = i;
		return b;
	endfunction

	function automatic void drop_slot(input int s);
		held[s]    = 1'b0;
		bytes_held = bytes_held - {1'b0, held_size[s]};
		evictions  = bump(evictions);
		push_word(KIND_EVICT, s, held_key[s]);
	endfunction

	// work out the result words of one accepted request
	function automatic void predict_request(input logic cmd, input logic [KEY_W-1:0] k,
		input logic [SIZE_W-1:0] sz);
		int n0, s, hit, free_slot;
		result_t w;
		n0 = expected_words.size();
		if (cmd == CMD_CLEAR) begin
			s = oldest_slot();
			while (s >= 0) begin
				drop_slot(s);
				s = oldest_slot();
			end
			bytes_held = '0;
			push_word(KIND_CLEARED, 0, k);
		end else if (capacity == 0 || sz == 0 || k == 0) begin
			push_word(KIND_BYPASS, 0, k);
		end else begin
			hit = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (held[i] && held_key[i] == k && held_size[i] == sz) hit = i;
			if (hit >= 0) begin
				to_front(hit);
				hits = bump(hits);
				push_word(KIND_HIT, hit, k);
			end else begin
				misses = bump(misses);
				if (sz > capacity) begin
					push_word(KIND_TOOBIG, 0, k);
				end else begin
					s = oldest_slot();
					while (bytes_held + {1'b0, sz} > {1'b0, capacity} && s >= 0) begin
						drop_slot(s);
						s = oldest_slot();
					end
					free_slot = -1;
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!held[i]) free_slot = i;
					if (free_slot < 0) begin
						s = oldest_slot();
						if (s >= 0) begin
							drop_slot(s);
							free_slot = s;
						end
					end
					if (free_slot >= 0) begin
						held[free_slot]      = 1'b1;
						held_key[free_slot]  = k;
						held_size[free_slot] = sz;
						bytes_held           = bytes_held + {1'b0, sz};
						to_front(free_slot);
						push_word(KIND_INSERT, free_slot, k);
					end
				end
			end
		end
		if (expected_words.size() > n0) begin
			w = expected_words[$];
			w.last = 1'b1;
			expected_words[$] = w;
		end
	endfunction

	// follow the channels and compare each result word
	always @(posedge clk or negedge arst_n) begin
		result_t exp_w;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			capacity   = '0;
			bytes_held = '0;
			hits       = '0;
			misses     = '0;
			evictions  = '0;
			fail_count <= 0;
			for (int i = 0; i < ENTRIES; i++) begin
				held[i]      = 1'b0;
				held_key[i]  = '0;
				held_size[i] = '0;
				rank[i]      = i;
			end
			expected_words.delete();
			pending_results = 0;
		end else begin
			if (cfg_we) capacity = cfg_wdata;
			if (res.valid && res.ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected, kind %0d", res.kind);
					errs++;
				end else begin
					exp_w = expected_words.pop_front();
					if (res.kind !== exp_w.kind) begin
						$error("kind: expected %0d, got %0d", exp_w.kind, res.kind);
						errs++;
					end
					if (res.slot !== exp_w.slot) begin
						$error("slot: expected %0d, got %0d", exp_w.slot, res.slot);
						errs++;
					end
					if (res.entry_key !== exp_w.entry_key) begin
						$error("entry_key: expected %h, got %h", exp_w.entry_key, res.entry_key);
						errs++;
					end
					if (res.used_bytes !== exp_w.used_bytes) begin
						$error("used_bytes: expected %0d, got %0d", exp_w.used_bytes,
							res.used_bytes);
						errs++;
					end
					if (res.hit_count !== exp_w.hit_count) begin
						$error("hit_count: expected %0d, got %0d", exp_w.hit_count, res.hit_count);
						errs++;
					end
					if (res.miss_count !== exp_w.miss_count) begin
						$error("miss_count: expected %0d, got %0d", exp_w.miss_count,
							res.miss_count);
						errs++;
					end
					if (res.evict_count !== exp_w.evict_count) begin
						$error("evict_count: expected %0d, got %0d", exp_w.evict_count,
							res.evict_count);
						errs++;
					end
					if (res.last !== exp_w.last) begin
						$error("last: expected %0d, got %0d", exp_w.last, res.last);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				predict_request(req.command, req.key, req.size_bytes);
			pending_results = expected_words.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== verif/tb_byte_capacity_lru_cache.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_capacity_lru_cache
// drives lookups, clears and capacity changes with random gaps on both sides;
// a checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_byte_capacity_lru_cache;
	import brlc_pkg::*;

	localparam int ENTRIES   = 16;
	localparam int MAX_CYC   = 1500000;
	localparam int DRAIN_CYC = 60;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	int                fail_count;
	int                pending_results;
	int                cycle_count;

	brlc_req_if req ();
	brlc_res_if res ();

	byte_capacity_lru_cache #(.ENTRIES(ENTRIES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	brlc_lru_checker #(.ENTRIES(ENTRIES)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req             (req),
		.res             (res),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// small pool of keys so that hits and evictions are frequent
	logic [KEY_W-1:0] key_pool [8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// timeout
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > MAX_CYC) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls, with calm stretches
	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			repeat (stall) begin
				@(posedge clk);
				res.ready <= 1'b0;
			end
			@(posedge clk);
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
			res.ready <= 1'b0;
		end
	end

	// valid stays high from one word straight into the next when there is no gap
	task automatic send_word(input logic cmd, input logic [KEY_W-1:0] k,
		input logic [SIZE_W-1:0] sz, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.command    <= cmd;
		req.key        <= k;
		req.size_bytes <= sz;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [SIZE_W-1:0] c);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] wide_key();
		return KEY_W'({$urandom, $urandom});
	endfunction

	// random phase: mostly pool keys and matching sizes, some noise
	task automatic random_phase(input int count, input logic [SIZE_W-1:0] sz_top);
		logic [KEY_W-1:0]  k;
		logic [SIZE_W-1:0] sz;
		int                pick;
		bit                calm;
		for (int i = 0; i < count; i++) begin
			calm = (i % 40) < 8;
			pick = $urandom_range(0, 99);
			k    = key_pool[$urandom_range(0, 7)];
			sz   = (k[7:0] % sz_top) + 1;
			if (pick < 3) begin
				send_word(CMD_CLEAR, wide_key(), sz, !calm);
			end else if (pick < 8) begin
				send_word(CMD_LOOKUP, wide_key(), SIZE_W'({$urandom, $urandom}), !calm);
			end else if (pick < 12) begin
				send_word(CMD_LOOKUP, $urandom_range(0, 1) ? 48'd0 : k,
					$urandom_range(0, 1) ? 40'd0 : sz, !calm);
			end else if (pick < 20) begin
				send_word(CMD_LOOKUP, k, $urandom_range(1, sz_top * 2), !calm);
			end else begin
				send_word(CMD_LOOKUP, k, sz, !calm);
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req.valid      = 1'b0;
		req.command    = CMD_LOOKUP;
		req.key        = '0;
		req.size_bytes = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// capacity zero: a lookup bypasses, a clear still clears
		send_word(CMD_LOOKUP, 48'h1234, 40'd5, 1'b1);
		send_word(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 40'd0, 1'b1);

		set_capacity(40'd100);
		// null key, zero size, too large
		send_word(CMD_LOOKUP, 48'd0, 40'd10, 1'b1);
		send_word(CMD_LOOKUP, 48'h55, 40'd0, 1'b1);
		send_word(CMD_LOOKUP, 48'h55, 40'd101, 1'b1);
		send_word(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
		// fill beyond the slot count, then hits, size mismatch and byte eviction
		for (int i = 1; i <= 18; i++)
			send_word(CMD_LOOKUP, 48'(i), 40'd1, 1'b0);
		send_word(CMD_LOOKUP, 48'd5, 40'd1, 1'b1);
		send_word(CMD_LOOKUP, 48'd5, 40'd2, 1'b1);
		send_word(CMD_LOOKUP, 48'hAAAA_AAAA_AAAA, 40'd100, 1'b1);
		// capacity lowered below what is held
		set_capacity(40'd10);
		send_word(CMD_LOOKUP, 48'h5555_5555_5555, 40'd3, 1'b1);
		send_word(CMD_CLEAR, 48'h77, 40'd0, 1'b1);

		for (int i = 0; i < 8; i++) key_pool[i] = wide_key() | 48'd1;
		key_pool[0] = 48'hFFFF_FFFF_FFFF;

		set_capacity(40'd40);
		random_phase(110, 40'd12);
		set_capacity(40'hFF_FFFF_FFFF);
		random_phase(60, 40'd1000);
		send_word(CMD_LOOKUP, key_pool[1], 40'hFF_FFFF_FFFF, 1'b1);
		set_capacity(40'd1);
		random_phase(50, 40'd1);
		set_capacity(40'd300);
		random_phase(110, 40'd60);
		// sender waits for every result before going on
		wait_idle();
		set_capacity(40'd20);
		random_phase(110, 40'd8);

		wait_idle();
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
